[hw/rtl/aop_pkg.sv]
`default_nettype none
package aop_pkg;

  localparam int FIELD_W = 32;
  // Width of a world corner or a direction component.
  localparam int AW = FIELD_W + 1;
  // Width of an overlap extent.
  localparam int OW = AW + 1;
  // Width of the sum of two squared directions.
  localparam int SQ_W = 2 * AW;
  // Width of the square root remainder.
  localparam int RW = AW + 3;

  typedef struct packed {
    logic signed [FIELD_W-1:0] self_min_x;
    logic signed [FIELD_W-1:0] self_min_y;
    logic signed [FIELD_W-1:0] self_max_x;
    logic signed [FIELD_W-1:0] self_max_y;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] other_min_x;
    logic signed [FIELD_W-1:0] other_min_y;
    logic signed [FIELD_W-1:0] other_max_x;
    logic signed [FIELD_W-1:0] other_max_y;
  } aop_req_t;

  typedef struct packed {
    logic                      overlapping;
    logic                      pushed;
    logic signed [FIELD_W-1:0] closest_x;
    logic signed [FIELD_W-1:0] closest_y;
    logic signed [FIELD_W-1:0] closest_z;
    logic signed [FIELD_W-1:0] push_x;
    logic signed [FIELD_W-1:0] push_y;
  } aop_rsp_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic                      overlapping;
    logic                      pushed;
    logic                      on_x;
    logic signed [FIELD_W-1:0] closest_x;
    logic signed [FIELD_W-1:0] closest_y;
    logic signed [FIELD_W-1:0] closest_z;
    logic [AW-1:0]             ax;
    logic [AW-1:0]             ay;
    logic                      dneg;
    logic [AW-1:0]             ad;
    logic [OW-1:0]             ov;
  } aop_cls_t;

endpackage
`default_nettype wire

[hw/rtl/aop_front.sv]
`default_nettype none
module aop_front
  import aop_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire aop_req_t req,
  output logic          push,
  input  wire logic     full,
  output aop_cls_t      cls
);

  logic     held;
  aop_req_t r;

  assign req_ready = !held || !full;
  assign push      = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_ready) begin
      held <= req_valid;
    end
    if (req_ready && req_valid) begin
      r <= req;
    end
  end

  logic signed [AW-1:0]   tmnx, tmny, tmxx, tmxy;
  logic signed [AW-1:0]   omnx, omny, omxx, omxy;
  logic signed [AW:0]     wx, wy, ex, ey;
  logic signed [AW-1:0]   cx, cy, dx, dy, mnx, mny, mxx, mxy;
  logic                   sep, px_lt, py_lt;
  logic [AW-1:0]          ax, ay;
  logic [OW-1:0]          ox, oy;

  always_comb begin
    omnx = AW'(r.other_min_x);
    omny = AW'(r.other_min_y);
    omxx = AW'(r.other_max_x);
    omxy = AW'(r.other_max_y);
    tmnx = AW'(r.self_min_x) + AW'(r.pos_x);
    tmny = AW'(r.self_min_y) + AW'(r.pos_y);
    tmxx = AW'(r.self_max_x) + AW'(r.pos_x);
    tmxy = AW'(r.self_max_y) + AW'(r.pos_y);
    wx = OW'(tmxx) - OW'(tmnx);
    wy = OW'(tmxy) - OW'(tmny);
    sep = (tmnx > omxx) || (tmxx < omnx) || (tmny > omxy) || (tmxy < omny);

    // Half-width tests are done doubled so they stay exact.
    if ((OW+1)'(r.pos_x) + (OW+1)'(r.pos_x) - (OW+1)'(wx) < (OW+1)'(omnx) + (OW+1)'(omnx)) begin
      cx = omnx;
    end else if ((OW+1)'(r.pos_x) + (OW+1)'(r.pos_x) + (OW+1)'(wx) >
                 (OW+1)'(omxx) + (OW+1)'(omxx)) begin
      cx = omxx;
    end else begin
      cx = AW'(r.pos_x);
    end
    if ((OW+1)'(r.pos_y) + (OW+1)'(r.pos_y) - (OW+1)'(wy) < (OW+1)'(omny) + (OW+1)'(omny)) begin
      cy = omny;
    end else if ((OW+1)'(r.pos_y) + (OW+1)'(r.pos_y) + (OW+1)'(wy) >
                 (OW+1)'(omxy) + (OW+1)'(omxy)) begin
      cy = omxy;
    end else begin
      cy = AW'(r.pos_y);
    end

    dx = AW'(r.pos_x) - cx;
    dy = AW'(r.pos_y) - cy;
    ax = dx[AW-1] ? AW'(-dx) : AW'(dx);
    ay = dy[AW-1] ? AW'(-dy) : AW'(dy);

    mxx = (tmxx < omxx) ? tmxx : omxx;
    mxy = (tmxy < omxy) ? tmxy : omxy;
    mnx = (tmnx > omnx) ? tmnx : omnx;
    mny = (tmny > omny) ? tmny : omny;
    ex = OW'(mxx) - OW'(mnx);
    ey = OW'(mxy) - OW'(mny);
    ox = ex[OW-1] ? OW'(-ex) : OW'(ex);
    oy = ey[OW-1] ? OW'(-ey) : OW'(ey);
    px_lt = ox < oy;
    py_lt = oy < ox;

    cls = '0;
    if (!sep) begin
      cls.overlapping = 1'b1;
      cls.pushed      = px_lt || py_lt;
      cls.on_x        = px_lt;
      cls.closest_x   = cx[FIELD_W-1:0];
      cls.closest_y   = cy[FIELD_W-1:0];
      cls.closest_z   = r.pos_z;
      cls.ax          = ax;
      cls.ay          = ay;
      cls.dneg        = px_lt ? dx[AW-1] : dy[AW-1];
      cls.ad          = px_lt ? ax : ay;
      cls.ov          = px_lt ? ox : oy;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/aop_fifo.sv]
`default_nettype none
module aop_fifo
  import aop_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire aop_cls_t wdata,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output aop_cls_t      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aop_cls_t        mem [DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/aop_back.sv]
`default_nettype none
module aop_back
  import aop_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     head_valid,
  input  wire aop_cls_t head,
  output logic          pop,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output aop_rsp_t      rsp
);

  localparam int DW = AW + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int MW = QW + OW;
  localparam logic [63:0] LIM_POS = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;

  // The whole pipe moves together whenever the output register can take an item.
  logic adv;
  assign adv = !rsp_valid || rsp_ready;
  assign pop = adv && head_valid;

  // Squares, then their sum.
  logic             a_v, b_v;
  aop_cls_t         a_c, b_c;
  logic [SQ_W-1:0]  sqx, sqy, b_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (adv) begin
      a_v <= head_valid;
      b_v <= a_v;
    end
    if (adv) begin
      a_c   <= head;
      sqx   <= head.ax * head.ax;
      sqy   <= head.ay * head.ay;
      b_c   <= a_c;
      b_rad <= sqx + sqy;
    end
  end

  // Square root, one result bit per stage.
  logic            s_v   [AW+1];
  aop_cls_t        s_c   [AW+1];
  logic [SQ_W-1:0] s_rad [AW+1];
  logic [RW-1:0]   s_rem [AW+1];
  logic [AW-1:0]   s_root[AW+1];

  assign s_v[0]    = b_v;
  assign s_c[0]    = b_c;
  assign s_rad[0]  = b_rad;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  for (genvar j = 0; j < AW; j++) begin : g_sqrt
    localparam int K = AW - 1 - j;
    logic [RW-1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {s_rem[j][RW-3:0], s_rad[j][2*K+1 -: 2]};
      trial  = RW'({s_root[j], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[j+1] <= 1'b0;
      end else if (adv) begin
        s_v[j+1] <= s_v[j];
      end
      if (adv) begin
        s_c[j+1]   <= s_c[j];
        s_rad[j+1] <= s_rad[j];
        if (rem_sh >= trial) begin
          s_rem[j+1]  <= rem_sh - trial;
          s_root[j+1] <= {s_root[j][AW-2:0], 1'b1};
        end else begin
          s_rem[j+1]  <= rem_sh;
          s_root[j+1] <= {s_root[j][AW-2:0], 1'b0};
        end
      end
    end
  end

  // Restoring division of the scaled direction by the length.
  logic          d_v  [QW+1];
  aop_cls_t      d_c  [QW+1];
  logic [DW-1:0] d_rem[QW+1];
  logic [AW-1:0] d_len[QW+1];
  logic [QW-1:0] d_q  [QW+1];

  assign d_v[0]   = s_v[AW];
  assign d_c[0]   = s_c[AW];
  assign d_rem[0] = {s_c[AW].ad, FRAC_BITS'(0)};
  assign d_len[0] = s_root[AW];
  assign d_q[0]   = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int I = FRAC_BITS - g;
    logic [DW-1:0] sub;
    assign sub = DW'(d_len[g]) << I;
    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[g+1] <= 1'b0;
      end else if (adv) begin
        d_v[g+1] <= d_v[g];
      end
      if (adv) begin
        d_c[g+1]   <= d_c[g];
        d_len[g+1] <= d_len[g];
        if (d_rem[g] >= sub) begin
          d_rem[g+1] <= d_rem[g] - sub;
          d_q[g+1]   <= d_q[g] | (QW'(1) << I);
        end else begin
          d_rem[g+1] <= d_rem[g];
          d_q[g+1]   <= d_q[g];
        end
      end
    end
  end

  // Unit component times overlap extent.
  logic          m_v;
  aop_cls_t      m_c;
  logic [MW-1:0] m_prod;
  logic [QW-1:0] q_fin;

  assign q_fin = (d_len[QW] == '0) ? '0 : d_q[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= d_v[QW];
    end
    if (adv) begin
      m_c    <= d_c[QW];
      m_prod <= q_fin * d_c[QW].ov;
    end
  end

  // Truncate, saturate and place the push on its axis.
  logic [MW+63:0] prod_ext;
  logic [63:0]    mag, sat, sval;
  aop_rsp_t       nxt;

  always_comb begin
    prod_ext = {64'd0, m_prod};
    mag      = prod_ext[63:0] >> FRAC_BITS;
    if (m_c.dneg) begin
      sat  = (mag > LIM_POS + 64'd1) ? LIM_POS + 64'd1 : mag;
      sval = 64'd0 - sat;
    end else begin
      sat  = (mag > LIM_POS) ? LIM_POS : mag;
      sval = sat;
    end
    nxt.overlapping = m_c.overlapping;
    nxt.pushed      = m_c.pushed;
    nxt.closest_x   = m_c.closest_x;
    nxt.closest_y   = m_c.closest_y;
    nxt.closest_z   = m_c.closest_z;
    nxt.push_x      = (m_c.pushed && m_c.on_x) ? sval[FIELD_W-1:0] : '0;
    nxt.push_y      = (m_c.pushed && !m_c.on_x) ? sval[FIELD_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= m_v;
    end
    if (adv) begin
      rsp <= nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/aabb_overlap_push_out.sv]
// Channel  Signals                        Direction  Content
// req      req_valid, req_ready, req      in         one box pair
// rsp      rsp_valid, rsp_ready, rsp      out        closest point and push
//
// One item per cycle is accepted and delivered when neither side stalls.
// Most of the pipe is 33 square root steps and FRAC_BITS + 1 divider
// steps, plus queue and staging.
// A stall on rsp freezes the back pipe; the queue keeps the front filling.
// Reset clears valid bits, queue pointers and queue count only.
`default_nettype none
module aabb_overlap_push_out
  import aop_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire aop_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output aop_rsp_t      rsp
);

  logic     f_push, q_full, q_pop, q_nempty;
  aop_cls_t f_cls, q_head;

  aop_front u_front (
    .clk, .rst, .req_valid, .req_ready, .req,
    .push(f_push), .full(q_full), .cls(f_cls)
  );

  aop_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst, .push(f_push), .wdata(f_cls), .full(q_full),
    .pop(q_pop), .not_empty(q_nempty), .rdata(q_head)
  );

  aop_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .head_valid(q_nempty), .head(q_head), .pop(q_pop),
    .rsp_valid, .rsp_ready, .rsp
  );

  a_push_needs_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pushed |-> rsp.overlapping)
    else $error("push reported for separated boxes");

  a_separated_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.overlapping |->
      rsp.closest_x == '0 && rsp.closest_y == '0 && rsp.closest_z == '0)
    else $error("separated item has a nonzero closest point");

  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.push_x == '0 || rsp.push_y == '0)
    else $error("push on both axes");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

endmodule
`default_nettype wire
